// ===== hdl/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants of the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

    // line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // field and register widths
    localparam int PIXEL_W   = 8;
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 13;
    localparam int ROW_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;

    // arithmetic widths
    localparam int SUM_W     = 10;   // weighted sum of one column or row
    localparam int GRAD_W    = 11;   // signed gradient
    localparam int ABS_W     = 10;   // gradient magnitude per axis
    localparam int SQ_W      = 20;   // one squared gradient
    localparam int SS_W      = 21;   // sum of squares
    localparam int ROOT_IN_W = 16;   // largest operand the root unit sees
    localparam int ROOT_W    = 17;

    localparam logic [ROOT_IN_W-1:0] ROOT_FIRST_BIT = 16'h4000;
    localparam logic [PIXEL_W-1:0]   MAG_MAX        = 8'd255;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // reset values of the configuration registers
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // one column of the 3x3 window
    typedef struct packed {
        logic [PIXEL_W-1:0] top;
        logic [PIXEL_W-1:0] mid;
        logic [PIXEL_W-1:0] bot;
    } win_col_t;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_KERN = 7'b0000100,
        ST_SQX  = 7'b0001000,
        ST_SQY  = 7'b0010000,
        ST_ROOT = 7'b0100000,
        ST_LOAD = 7'b1000000
    } state_t;

endpackage

// ===== hdl/sgm_ram.sv =====
// ----------------------------------------------------------------------------
// sgm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sgm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/sobel_gradient_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_top
// 3x3 Sobel gradient magnitude over a raster pixel stream, with two line
// stores in RAM, replicated borders and an 8-step bit-pair square root.
// ----------------------------------------------------------------------------
// sequencing: an accepted item passes ST_READ and, for each of its results, ST_KERN,
//   ST_SQX, ST_SQY, the serial root in ST_ROOT (skipped when the magnitude saturates)
//   and ST_LOAD, which waits for a free output register; the next item is taken only
//   back in ST_IDLE
// reset: registers take width 640 and height 480, counters and window clear;
//   line store contents stay undefined until written
module sobel_gradient_magnitude_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sgm_pkg::PIXEL_W-1:0]      s_axis_tdata,   // [7:0] pixel
    input  logic                             s_axis_tuser,   // [0] drain
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sgm_pkg::PIXEL_W-1:0]      m_axis_tdata,   // [7:0] magnitude
    output logic                             m_axis_tlast,   // last_of_frame
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import sgm_pkg::*;

    // weighted sum a + 2b + c of three samples
    function automatic logic [SUM_W-1:0] wsum(
        input logic [PIXEL_W-1:0] a,
        input logic [PIXEL_W-1:0] b,
        input logic [PIXEL_W-1:0] c
    );
        wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    // absolute difference of two weighted sums
    function automatic logic [ABS_W-1:0] absdiff(
        input logic [SUM_W-1:0] p,
        input logic [SUM_W-1:0] q
    );
        logic signed [GRAD_W-1:0] d;
        d = signed'({1'b0, p}) - signed'({1'b0, q});
        absdiff = (d < 0) ? ABS_W'(-d) : ABS_W'(d);
    endfunction

    state_t state_reg, state_next;

    logic [WIDTH_W-1:0]  width_reg,  width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [ADDR_W-1:0]   col_reg,    col_next;
    logic [ROW_W-1:0]    row_reg,    row_next;

    // item under work
    logic [PIXEL_W-1:0]  cur_pix_reg,      cur_pix_next;
    logic                cur_drain_reg,    cur_drain_next;
    logic [ADDR_W-1:0]   cur_col_reg,      cur_col_next;
    logic                cur_row_zero_reg, cur_row_zero_next;
    logic                cur_row_ge2_reg,  cur_row_ge2_next;
    logic                cur_col_zero_reg, cur_col_zero_next;
    logic                cur_last_reg,     cur_last_next;
    logic                cur_lof_reg,      cur_lof_next;

    // pending results and the datapath
    logic                need_a_reg,  need_a_next;
    logic                need_b_reg,  need_b_next;
    logic                res_lof_reg, res_lof_next;
    win_col_t            win0_reg, win0_next;
    win_col_t            win1_reg, win1_next;
    win_col_t            win2_reg, win2_next;
    logic [ABS_W-1:0]    absx_reg, absx_next;
    logic [ABS_W-1:0]    absy_reg, absy_next;
    logic [SQ_W-1:0]     sq_reg,   sq_next;
    logic [SS_W-1:0]     rem_reg,  rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_IN_W-1:0] bit_reg, bit_next;
    logic                sat_reg,  sat_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0]  m_data_reg,  m_data_next;
    logic                m_last_reg,  m_last_next;

    // effective geometry
    logic [ADDR_W-1:0]   w_m1;
    logic [HEIGHT_W-1:0] h_eff;
    logic                last_col;
    logic                s_accept;

    // line store ports
    logic [PIXEL_W-1:0]  prev_rdata, older_rdata;
    logic                prev_we, older_we;
    logic [PIXEL_W-1:0]  prev_wdata, older_wdata;

    // window fill and kernel signals
    win_col_t            new_col;
    win_col_t            kl, kc, kr;
    logic [SS_W-1:0]     ss;
    logic [ROOT_W-1:0]   trial;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // width clamped to 1..MAX_WIDTH, as last column index
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_m1 = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_m1 = ADDR_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = ADDR_W'(width_reg - 12'd1);
        end
    end

    assign h_eff    = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    assign last_col = (col_reg >= w_m1);

    // sample column entering the window
    always_comb
    begin
        new_col.mid = prev_rdata;
        new_col.top = cur_row_ge2_reg ? older_rdata : prev_rdata;
        if (cur_drain_reg)
        begin
            new_col.bot = cur_row_zero_reg ? '0 : prev_rdata;
        end
        else
        begin
            new_col.bot = cur_pix_reg;
        end
    end

    // line store write-back of the item under work
    assign prev_we     = (state_reg == ST_READ);
    assign prev_wdata  = new_col.bot;
    assign older_we    = (state_reg == ST_READ) & ~cur_row_zero_reg;
    assign older_wdata = new_col.mid;

    // kernel columns: interior result first, then the replicated right edge
    always_comb
    begin
        if (need_a_reg)
        begin
            kl = win0_reg;
            kc = win1_reg;
            kr = win2_reg;
        end
        else
        begin
            kl = win1_reg;
            kc = win2_reg;
            kr = win2_reg;
        end
    end

    assign ss    = SS_W'(sq_reg) + SS_W'(absy_reg) * SS_W'(absy_reg);
    assign trial = root_reg + ROOT_W'(bit_reg);

    // sequencer and datapath next state
    always_comb
    begin
        state_next        = state_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        cur_pix_next      = cur_pix_reg;
        cur_drain_next    = cur_drain_reg;
        cur_col_next      = cur_col_reg;
        cur_row_zero_next = cur_row_zero_reg;
        cur_row_ge2_next  = cur_row_ge2_reg;
        cur_col_zero_next = cur_col_zero_reg;
        cur_last_next     = cur_last_reg;
        cur_lof_next      = cur_lof_reg;
        need_a_next       = need_a_reg;
        need_b_next       = need_b_reg;
        res_lof_next      = res_lof_reg;
        win0_next         = win0_reg;
        win1_next         = win1_reg;
        win2_next         = win2_reg;
        absx_next         = absx_reg;
        absy_next         = absy_reg;
        sq_next           = sq_reg;
        rem_next          = rem_reg;
        root_next         = root_reg;
        bit_next          = bit_reg;
        sat_next          = sat_reg;
        m_valid_next      = m_valid_reg & ~m_axis_tready;
        m_data_next       = m_data_reg;
        m_last_next       = m_last_reg;

        // configuration registers
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            // take an item, start the line store reads, advance the raster
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    cur_pix_next      = s_axis_tdata;
                    cur_drain_next    = s_axis_tuser;
                    cur_col_next      = col_reg;
                    cur_row_zero_next = (row_reg == '0);
                    cur_row_ge2_next  = (row_reg >= ROW_W'(2));
                    cur_col_zero_next = (col_reg == '0);
                    cur_last_next     = last_col;
                    cur_lof_next      = (row_reg == h_eff);
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = (row_reg >= h_eff) ? '0 : row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + ADDR_W'(1);
                    end
                    state_next = ST_READ;
                end
            end
            // line store data back: shift the window, decide the results
            ST_READ:
            begin
                if (cur_col_zero_reg)
                begin
                    win0_next = new_col;
                    win1_next = new_col;
                end
                else
                begin
                    win0_next = win1_reg;
                    win1_next = win2_reg;
                end
                win2_next   = new_col;
                need_a_next = ~cur_row_zero_reg & ~cur_col_zero_reg;
                need_b_next = ~cur_row_zero_reg & cur_last_reg;
                if (~cur_row_zero_reg & (~cur_col_zero_reg | cur_last_reg))
                begin
                    state_next = ST_KERN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            // gradients of the next pending result
            ST_KERN:
            begin
                absx_next = absdiff(wsum(kr.top, kr.mid, kr.bot),
                                    wsum(kl.top, kl.mid, kl.bot));
                absy_next = absdiff(wsum(kl.bot, kc.bot, kr.bot),
                                    wsum(kl.top, kc.top, kr.top));
                if (need_a_reg)
                begin
                    need_a_next  = 1'b0;
                    res_lof_next = 1'b0;
                end
                else
                begin
                    need_b_next  = 1'b0;
                    res_lof_next = cur_lof_reg;
                end
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                sq_next    = SQ_W'(absx_reg) * SQ_W'(absx_reg);
                state_next = ST_SQY;
            end
            // sum of squares, saturation check, root setup
            ST_SQY:
            begin
                rem_next   = ss;
                root_next  = '0;
                bit_next   = ROOT_FIRST_BIT;
                sat_next   = (ss[SS_W-1:ROOT_IN_W] != '0);
                state_next = (ss[SS_W-1:ROOT_IN_W] != '0) ? ST_LOAD : ST_ROOT;
            end
            // one bit pair of the square root per cycle
            ST_ROOT:
            begin
                if (rem_reg >= SS_W'(trial))
                begin
                    rem_next  = rem_reg - SS_W'(trial);
                    root_next = (root_reg >> 1) + ROOT_W'(bit_reg);
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == ROOT_IN_W'(1))
                begin
                    state_next = ST_LOAD;
                end
            end
            // hand the result to the output register once it is free
            ST_LOAD:
            begin
                if (~m_valid_reg | m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = sat_reg ? MAG_MAX : root_reg[PIXEL_W-1:0];
                    m_last_next  = res_lof_reg;
                    state_next   = (need_a_reg | need_b_reg) ? ST_KERN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            need_a_reg  <= 1'b0;
            need_b_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            win0_reg    <= '0;
            win1_reg    <= '0;
            win2_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            need_a_reg  <= need_a_next;
            need_b_reg  <= need_b_next;
            m_valid_reg <= m_valid_next;
            win0_reg    <= win0_next;
            win1_reg    <= win1_next;
            win2_reg    <= win2_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_pix_reg      <= cur_pix_next;
        cur_drain_reg    <= cur_drain_next;
        cur_col_reg      <= cur_col_next;
        cur_row_zero_reg <= cur_row_zero_next;
        cur_row_ge2_reg  <= cur_row_ge2_next;
        cur_col_zero_reg <= cur_col_zero_next;
        cur_last_reg     <= cur_last_next;
        cur_lof_reg      <= cur_lof_next;
        res_lof_reg      <= res_lof_next;
        absx_reg         <= absx_next;
        absy_reg         <= absy_next;
        sq_reg           <= sq_next;
        rem_reg          <= rem_next;
        root_reg         <= root_next;
        bit_reg          <= bit_next;
        sat_reg          <= sat_next;
        m_data_reg       <= m_data_next;
        m_last_reg       <= m_last_next;
    end

    // row directly above the incoming row
    sgm_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (MAX_WIDTH)
    ) u_prev_row (
        .clk    (clk),
        .we     (prev_we),
        .waddr  (cur_col_reg),
        .wdata  (prev_wdata),
        .re     (s_accept),
        .raddr  (col_reg),
        .rdata  (prev_rdata)
    );

    // row two above the incoming row
    sgm_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (MAX_WIDTH)
    ) u_older_row (
        .clk    (clk),
        .we     (older_we),
        .waddr  (cur_col_reg),
        .wdata  (older_wdata),
        .re     (s_accept),
        .raddr  (col_reg),
        .rdata  (older_rdata)
    );

endmodule

// ===== tb/sv/sobel_gradient_magnitude_top_tb.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_top_tb
// Streams grayscale frames through the Sobel magnitude block and compares
// every result with a behavioral copy of the window, line stores and root.
// Covers border replication, drain rows, size fallbacks, mid-frame resizing,
// oversized width and tall height, and random frames under random stalls.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_top_tb;

    import sgm_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 820;
    localparam int CALM_ITEMS    = 680;

    // one expected result item
    typedef struct packed {
        logic [PIXEL_W-1:0] magnitude;
        logic               frame_end;
    } mag_result_t;

    // content styles for random frames
    typedef enum int { PIX_NOISE, PIX_SMOOTH, PIX_BINARY } pix_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIXEL_W-1:0]    s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIXEL_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model of the block
    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic [PIXEL_W-1:0]    older_line [MAX_WIDTH];
    logic [PIXEL_W-1:0]    prev_line  [MAX_WIDTH];
    win_col_t              window [3];
    int                    col_pos;
    int                    row_pos;

    mag_result_t           expected_mags [$];
    int                    failures;
    int                    results_seen;
    int                    items_sent;
    bit                    idle_on;

    sobel_gradient_magnitude_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------

    function automatic int active_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        return (height_reg == '0) ? 1 : int'(height_reg);
    endfunction

    // sobel kernels over three window columns, floor root, saturated
    function automatic logic [PIXEL_W-1:0] gradient_magnitude(win_col_t lc, win_col_t cc,
                                                              win_col_t rc);
        int gx;
        int gy;
        int energy;
        int root;
        int b;
        gx = int'(rc.top) + 2 * int'(rc.mid) + int'(rc.bot)
           - int'(lc.top) - 2 * int'(lc.mid) - int'(lc.bot);
        gy = int'(lc.bot) + 2 * int'(cc.bot) + int'(rc.bot)
           - int'(lc.top) - 2 * int'(cc.top) - int'(rc.top);
        energy = gx * gx + gy * gy;
        if (energy >= 65536)
            return MAG_MAX;
        root = 0;
        for (b = 7; b >= 0; b--)
            if ((root + (1 << b)) * (root + (1 << b)) <= energy)
                root += 1 << b;
        return root[PIXEL_W-1:0];
    endfunction

    // one accepted pixel: update stores and window, queue the results it causes
    function automatic void raster_step(input logic [PIXEL_W-1:0] pixel, input logic drain);
        int       w;
        int       h;
        bit       in_store;
        bit       at_row_end;
        win_col_t incoming;
        w          = active_width();
        h          = active_height();
        in_store   = col_pos < MAX_WIDTH;
        at_row_end = col_pos >= w - 1;

        // column entering the window, edges replicated
        incoming.mid = in_store ? prev_line[col_pos] : '0;
        incoming.top = (row_pos >= 2 && in_store) ? older_line[col_pos] : incoming.mid;
        if (drain)
            incoming.bot = (row_pos == 0) ? '0 : incoming.mid;
        else
            incoming.bot = pixel;

        // line stores shift down one row
        if (in_store)
        begin
            if (row_pos >= 1)
                older_line[col_pos] = incoming.mid;
            prev_line[col_pos] = incoming.bot;
        end

        // left edge fills the whole window
        if (col_pos == 0)
        begin
            window[0] = incoming;
            window[1] = incoming;
            window[2] = incoming;
        end
        else
        begin
            window[0] = window[1];
            window[1] = window[2];
            window[2] = incoming;
        end

        // results for the row above
        if (row_pos >= 1)
        begin
            if (col_pos >= 1)
                expected_mags.push_back({gradient_magnitude(window[0], window[1], window[2]),
                                         1'b0});
            if (at_row_end)
                expected_mags.push_back({gradient_magnitude(window[1], window[2], window[2]),
                                         row_pos == h});
        end

        // raster position
        if (at_row_end)
        begin
            col_pos = 0;
            row_pos = (row_pos >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: config writes, accepted pixels and result checking
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : monitor
        mag_result_t got;
        mag_result_t want;
        if (rst_n)
        begin
            // register writes as the block takes them
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data[WIDTH_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[HEIGHT_W-1:0];
            end

            // pixels feed the model
            if (s_axis_tvalid && s_axis_tready)
            begin
                raster_step(s_axis_tdata, s_axis_tuser);
                items_sent++;
            end

            // each result against the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata, m_axis_tlast};
                results_seen++;
                if (expected_mags.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d unexpected: magnitude %0d last %0b",
                                 results_seen, got.magnitude, got.frame_end);
                end
                else
                begin
                    want = expected_mags.pop_front();
                    if (got !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("result %0d: expected magnitude %0d last %0b, got %0d last %0b",
                                     results_seen, want.magnitude, want.frame_end,
                                     got.magnitude, got.frame_end);
                    end
                end
            end
        end
    end

    // output backpressure in random bursts
    initial
    begin : output_stall
        int hold;
        hold          = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 12);
            m_axis_tready <= (hold == 0);
        end
    end

    // watchdog on cycles with no item moving anywhere
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sobel_gradient_magnitude_top_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    // one pixel item, with an optional gap in front
    task automatic send_item(input logic [PIXEL_W-1:0] pixel, input logic drain);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel;
        s_axis_tuser  <= drain;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // stop the stream, collect every pending result, let the datapath empty
    task automatic wait_for_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_mags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_geometry(input int width, input int height);
        wait_for_quiet();
        write_register(REG_IMAGE_WIDTH, width);
        write_register(REG_IMAGE_HEIGHT, height);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel(pix_style_t style, int base, int spread);
        case (style)
            PIX_SMOOTH: return PIXEL_W'(base + int'($urandom_range(0, spread)));
            PIX_BINARY: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            default:    return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame up to the end of its flush row, with stray drains, real pixels
    // in the flush row and at most one resize of the frame along the way
    task automatic stream_frame(input int stray_pct, input int resize_permille);
        pix_style_t style;
        int         spread;
        int         base;
        bit         resized;
        style   = pix_style_t'($urandom_range(0, 2));
        spread  = 1 << $urandom_range(1, 6);
        base    = $urandom_range(0, 255 - spread);
        resized = 1'b0;
        do
        begin
            if (row_pos >= active_height())
                send_item(pick_pixel(style, base, spread), $urandom_range(0, 9) != 0);
            else
                send_item(pick_pixel(style, base, spread), $urandom_range(0, 99) < stray_pct);
            if (!resized && (row_pos != 0 || col_pos != 0) &&
                $urandom_range(0, 999) < resize_permille)
            begin
                resized = 1'b1;
                // width only narrower, so no row reads columns it never wrote
                if ($urandom_range(0, 1) == 1)
                    set_geometry($urandom_range(1, active_width()), height_reg);
                else
                    set_geometry(width_reg, $urandom_range(1, 8));
            end
        end
        while (row_pos != 0 || col_pos != 0);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_border_cases();
        set_geometry(4, 3);
        // row 0: black, white, a drain standing in for black, white
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        // row 1: hard vertical edge
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        // row 2: a drain copies the row above
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        // flush row with one real pixel among drains
        send_item(8'h00, 1'b1);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h4D, 1'b1);
        // width and height zero fall back to a single pixel
        set_geometry(0, 0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_mid_frame_resize();
        set_geometry(4, 4);
        repeat (4) send_item(PIXEL_W'($urandom_range(0, 255)), 1'b0);
        repeat (2) send_item(PIXEL_W'($urandom_range(0, 255)), 1'b0);
        // column already past the new last column ends the row
        set_geometry(2, 4);
        send_item(PIXEL_W'($urandom_range(0, 255)), 1'b0);
        repeat (2) send_item(PIXEL_W'($urandom_range(0, 255)), 1'b0);
        // row beyond the new height becomes the flush row, no frame end flag
        set_geometry(2, 1);
        repeat (2) send_item(PIXEL_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_widest_rows();
        // width above the store size saturates, height zero means one row;
        // the row is then cut short by a narrower width
        set_geometry(4095, 0);
        repeat (24) send_item(PIXEL_W'($urandom_range(0, 255)), 1'b0);
        set_geometry(24, 0);
        stream_frame(3, 0);
    endtask

    task automatic test_tallest_column();
        // a height that needs all 13 bits, then the frame ends early at a lower height
        set_geometry(1, 4096);
        repeat (10) send_item(PIXEL_W'($urandom_range(0, 255)), 1'b0);
        set_geometry(1, 12);
        stream_frame(3, 0);
    endtask

    task automatic test_random_frames();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            // some frames run without stalls, the tail runs without any
            idle_on = (items_sent - start < CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                set_geometry($urandom_range(1, 48), $urandom_range(1, 6));
            else
                set_geometry($urandom_range(1, 12), $urandom_range(1, 5));
            stream_frame(6, 150);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_data      = '0;
        idle_on       = 1'b1;
        failures      = 0;
        results_seen  = 0;
        items_sent    = 0;
        width_reg     = WIDTH_RESET;
        height_reg    = HEIGHT_RESET;
        col_pos       = 0;
        row_pos       = 0;
        foreach (older_line[k])
            older_line[k] = '0;
        foreach (prev_line[k])
            prev_line[k] = '0;
        foreach (window[k])
            window[k] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_border_cases();
        test_mid_frame_resize();
        test_widest_rows();
        test_tallest_column();
        test_random_frames();
        wait_for_quiet();

        if (failures == 0 && expected_mags.size() == 0)
            $display("sobel_gradient_magnitude_top_tb: done, clean");
        else
            $display("sobel_gradient_magnitude_top_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sgm_pkg.sv
hdl/sgm_ram.sv
hdl/sobel_gradient_magnitude_top.sv
tb/sv/sobel_gradient_magnitude_top_tb.sv
